FILE: rtl/pema_pkg.sv
`timescale 1ns / 1ps
package pema_pkg;
    localparam int unsigned MONTHS = 12;
    localparam int unsigned HOURS  = 24;
    localparam int unsigned HOUR_ENTRIES = MONTHS * HOURS;
    localparam int unsigned HIDX_W = 9;
    localparam int unsigned NUM_W  = 40;
    localparam int unsigned QUO_W  = 41;
    localparam int unsigned DEN_W  = 48;
    localparam logic [15:0] DEFAULT_BPK = 16'd1000;
    localparam logic [15:0] FLOOR_RESET = 16'd9999;
    localparam logic [15:0] EST_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_PULSE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_READ3 = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_LOST   = 3'd0,
        ST_BEAT   = 3'd1,
        ST_KWH    = 3'd2,
        ST_LOADED = 3'd3,
        ST_READ   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_BPK = 2'd0,
        REG_GAP = 2'd1,
        REG_MINB = 2'd2,
        REG_NUM = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_DIV,
        S_WRITE,
        S_OUT
    } fsm_t;

    // divider control between sequencer and divider unit
    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage

FILE: rtl/pema_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module pema_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pema_pkg::NUM_W-1:0]  numer,
    input  logic [pema_pkg::DEN_W-1:0]  denom,
    output logic                        busy,
    output logic [15:0]                 quot_sat
);
    logic [pema_pkg::NUM_W-1:0] q_reg, q_next;
    logic [pema_pkg::DEN_W:0]   r_reg, r_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [pema_pkg::DEN_W:0]   trial;

    // one shift-subtract step
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[pema_pkg::DEN_W-1:0], q_reg[pema_pkg::NUM_W-1]};
        if (start) begin
            q_next    = numer;
            r_next    = '0;
            cnt_next  = 6'(pema_pkg::NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, denom}) begin
                r_next = trial - {1'b0, denom};
                q_next = {q_reg[pema_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[pema_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy     = busy_reg;
    assign quot_sat = (q_reg[pema_pkg::NUM_W-1:16] != '0) ? pema_pkg::EST_MAX : q_reg[15:0];
endmodule

FILE: rtl/pema_counter_mem.sv
`timescale 1ns / 1ps
// month and month-hour counter memories, registered read
module pema_counter_mem (
    input  logic                          aclk,
    input  logic [3:0]                    mon_addr,
    input  logic [pema_pkg::HIDX_W-1:0]   hour_addr,
    input  logic                          we,
    input  logic [15:0]                   mon_wdata,
    input  logic [7:0]                    hour_wdata,
    output logic [15:0]                   mon_rdata,
    output logic [7:0]                    hour_rdata
);
    logic [15:0] mon_mem  [pema_pkg::MONTHS];
    logic [7:0]  hour_mem [pema_pkg::HOUR_ENTRIES];

    always_ff @(posedge aclk) begin
        if (we) begin
            mon_mem[mon_addr]   <= mon_wdata;
            hour_mem[hour_addr] <= hour_wdata;
        end
        mon_rdata  <= mon_mem[mon_addr];
        hour_rdata <= hour_mem[hour_addr];
    end
endmodule

FILE: rtl/pulse_energy_meter_accumulator.sv
`timescale 1ns / 1ps
// Pulse energy meter accumulator. After reset the block clears its month and
// hour counter memories and takes no item meanwhile. A pulse edge that counts
// as a beat with a nonzero gap waits in the divide state for the 40-step
// serial divider for the current estimate. A beat without an estimate waits
// there for the 16-step serial remainder for the kWh wrap or the checkpoint
// test. Every other item passes without waiting through memory read, write
// back and result register. One item is in work at a time; the result waits
// in an output register, and the next item is taken in the cycle after that
// result is accepted.
module pulse_energy_meter_accumulator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], time_ms[33:2], month[37:34], hour[42:38], balance_value[74:43]
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], save_request[3], relay_closed[4], current_estimate[20:5],
    // max_current[36:21], min_current[52:37], lifetime_kwh[84:53],
    // prepaid_balance[116:85], month_kwh[132:117], hour_kwh[140:133],
    // lost_pulses[172:141], lifetime_beats[204:173]
    output logic [207:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    // configuration registers
    logic [15:0] bpk_cfg_reg;
    logic [15:0] gap_cfg_reg;
    logic [31:0] minb_cfg_reg;
    logic [39:0] num_cfg_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpk_cfg_reg  <= 16'd1000;
            gap_cfg_reg  <= 16'd10;
            minb_cfg_reg <= 32'd1;
            num_cfg_reg  <= 40'd30000000000;
        end else if (cfg_wr) begin
            unique case (pema_pkg::reg_idx_t'(cfg_idx))
                pema_pkg::REG_BPK:  bpk_cfg_reg  <= pwdata[15:0];
                pema_pkg::REG_GAP:  gap_cfg_reg  <= pwdata[15:0];
                pema_pkg::REG_MINB: minb_cfg_reg <= pwdata[31:0];
                pema_pkg::REG_NUM:  num_cfg_reg  <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (pema_pkg::reg_idx_t'(cfg_idx))
            pema_pkg::REG_BPK:  prdata = {48'd0, bpk_cfg_reg};
            pema_pkg::REG_GAP:  prdata = {48'd0, gap_cfg_reg};
            pema_pkg::REG_MINB: prdata = {32'd0, minb_cfg_reg};
            pema_pkg::REG_NUM:  prdata = {24'd0, num_cfg_reg};
            default:            prdata = '0;
        endcase
    end

    // input fields
    logic [1:0]  in_cmd;
    logic [31:0] in_time;
    logic [3:0]  in_mon;
    logic [4:0]  in_hr;
    logic [31:0] in_bval;
    assign in_cmd  = s_tdata[1:0];
    assign in_time = s_tdata[33:2];
    assign in_mon  = s_tdata[37:34];
    assign in_hr   = s_tdata[42:38];
    assign in_bval = s_tdata[74:43];

    // latched item
    logic [1:0]  cmd_reg;
    logic [31:0] time_reg, bval_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  hr_reg;

    // scalar state
    logic [15:0] beat_in_kwh_reg;
    logic [31:0] total_beats_reg, last_edge_reg, last_beat_reg;
    logic        edge_seen_reg, beat_seen_reg;
    logic [15:0] peak_reg, floor_reg;
    logic [31:0] kwh_reg, balance_reg, glitch_reg;
    logic        relay_reg;

    // per-item intermediate results
    logic [2:0]  status_reg;
    logic        save_reg;
    logic [15:0] est_reg;
    logic        do_mem_reg;
    logic        in_range_reg;
    logic [31:0] gap_reg;
    logic [47:0] den_reg;

    // serial remainder unit state
    logic [15:0] mod_rem_reg, mod_dvd_reg, mod_dsr_reg;
    logic [4:0]  mod_cnt_reg;
    logic        mod_busy_reg;

    pema_pkg::fsm_t state_reg, state_next;
    logic [pema_pkg::HIDX_W-1:0] clr_reg;
    logic        out_valid_reg;
    logic [207:0] out_data_reg;

    // memory interface
    logic [3:0]  mon_addr;
    logic [pema_pkg::HIDX_W-1:0] hour_addr;
    logic        mem_we;
    logic [15:0] mon_wdata, mon_rdata;
    logic [7:0]  hour_wdata, hour_rdata;
    logic [pema_pkg::HIDX_W-1:0] hidx;

    assign hidx = pema_pkg::HIDX_W'(mon_reg) * pema_pkg::HIDX_W'(pema_pkg::HOURS)
                + pema_pkg::HIDX_W'(hr_reg);

    always_comb begin
        if (state_reg == pema_pkg::S_CLEAR) begin
            mon_addr  = (clr_reg < pema_pkg::HIDX_W'(pema_pkg::MONTHS)) ? clr_reg[3:0] : 4'd0;
            hour_addr = clr_reg;
        end else begin
            mon_addr  = mon_reg;
            hour_addr = hidx;
        end
    end
    assign mem_we     = (state_reg == pema_pkg::S_CLEAR) ||
                        (state_reg == pema_pkg::S_WRITE && do_mem_reg);
    assign mon_wdata  = (state_reg == pema_pkg::S_CLEAR) ? 16'd0 : mon_rdata + 16'd1;
    assign hour_wdata = (state_reg == pema_pkg::S_CLEAR) ? 8'd0 : hour_rdata + 8'd1;

    pema_counter_mem u_mem (
        .aclk       (aclk),
        .mon_addr   (mon_addr),
        .hour_addr  (hour_addr),
        .we         (mem_we),
        .mon_wdata  (mon_wdata),
        .hour_wdata (hour_wdata),
        .mon_rdata  (mon_rdata),
        .hour_rdata (hour_rdata)
    );

    // divider
    pema_pkg::div_ctl_t div_ctl;
    logic [15:0] quot;
    pema_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .numer    (num_cfg_reg),
        .denom    (den_reg),
        .busy     (div_ctl.busy),
        .quot_sat (quot)
    );

    logic s_acc;
    assign s_tready = (state_reg == pema_pkg::S_IDLE) && !out_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pema_pkg::S_CLEAR:
                if (clr_reg == pema_pkg::HIDX_W'(pema_pkg::HOUR_ENTRIES - 1))
                    state_next = pema_pkg::S_IDLE;
            pema_pkg::S_IDLE:  if (s_acc) state_next = pema_pkg::S_READ;
            pema_pkg::S_READ:  state_next = pema_pkg::S_DIV;
            pema_pkg::S_DIV:
                if (!div_ctl.busy && !mod_busy_reg) state_next = pema_pkg::S_WRITE;
            pema_pkg::S_WRITE: state_next = pema_pkg::S_OUT;
            pema_pkg::S_OUT:   state_next = pema_pkg::S_IDLE;
            default:           state_next = pema_pkg::S_IDLE;
        endcase
    end

    // pulse decision, computed in read state
    logic        is_pulse, glitch, need_est;
    logic [15:0] bpk_eff, div_n, beat_next;
    logic [33:0] div_prod;
    logic [31:0] gap_c;
    logic        kwh_done;
    always_comb begin
        is_pulse  = (cmd_reg == pema_pkg::CMD_PULSE);
        glitch    = edge_seen_reg && ((time_reg - last_edge_reg) <= {16'd0, gap_cfg_reg});
        bpk_eff   = (bpk_cfg_reg == 16'd0) ? pema_pkg::DEFAULT_BPK : bpk_cfg_reg;
        // bpk / 100 by reciprocal multiplication, exact over 16 bits
        div_prod  = 34'(bpk_eff) * 34'd167773;
        div_n     = {6'd0, div_prod[33:24]};
        if (div_n == 16'd0) div_n = 16'd1;
        gap_c     = beat_seen_reg ? time_reg - last_beat_reg : 32'd0;
        need_est  = is_pulse && !glitch && (gap_c != 32'd0);
        beat_next = beat_in_kwh_reg + 16'd1;
        kwh_done  = beat_next >= bpk_eff;
    end
    assign div_ctl.start = (state_reg == pema_pkg::S_READ) && need_est;

    // serial remainder: beat count mod bpk on a kwh, else mod checkpoint divisor
    logic        mod_start;
    logic [16:0] mod_trial;
    logic [15:0] mod_rem_next, mod_dvd_next, mod_dsr_next;
    logic [4:0]  mod_cnt_next;
    logic        mod_busy_next;
    assign mod_start = (state_reg == pema_pkg::S_READ) && is_pulse && !glitch;

    always_comb begin
        mod_rem_next  = mod_rem_reg;
        mod_dvd_next  = mod_dvd_reg;
        mod_dsr_next  = mod_dsr_reg;
        mod_cnt_next  = mod_cnt_reg;
        mod_busy_next = mod_busy_reg;
        mod_trial     = {mod_rem_reg, mod_dvd_reg[15]};
        if (mod_start) begin
            mod_rem_next  = '0;
            mod_dvd_next  = beat_next;
            mod_dsr_next  = kwh_done ? bpk_eff : div_n;
            mod_cnt_next  = 5'd16;
            mod_busy_next = 1'b1;
        end else if (mod_busy_reg) begin
            if (mod_trial >= {1'b0, mod_dsr_reg}) begin
                mod_rem_next = 16'(mod_trial - {1'b0, mod_dsr_reg});
            end else begin
                mod_rem_next = mod_trial[15:0];
            end
            mod_dvd_next = {mod_dvd_reg[14:0], 1'b0};
            mod_cnt_next = mod_cnt_reg - 5'd1;
            if (mod_cnt_reg == 5'd1) begin
                mod_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_busy_reg <= 1'b0;
            mod_cnt_reg  <= '0;
        end else begin
            mod_busy_reg <= mod_busy_next;
            mod_cnt_reg  <= mod_cnt_next;
        end
        mod_rem_reg <= mod_rem_next;
        mod_dvd_reg <= mod_dvd_next;
        mod_dsr_reg <= mod_dsr_next;
    end

    logic in_rng;
    assign in_rng = (mon_reg < 4'(pema_pkg::MONTHS)) && (hr_reg < 5'(pema_pkg::HOURS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pema_pkg::S_CLEAR;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            beat_in_kwh_reg <= '0;
            total_beats_reg <= '0;
            last_edge_reg   <= '0;
            last_beat_reg   <= '0;
            edge_seen_reg   <= 1'b0;
            beat_seen_reg   <= 1'b0;
            peak_reg        <= '0;
            floor_reg       <= pema_pkg::FLOOR_RESET;
            kwh_reg         <= '0;
            balance_reg     <= '0;
            glitch_reg      <= '0;
            relay_reg       <= 1'b1;
            do_mem_reg      <= 1'b0;
            est_reg         <= '0;
            status_reg      <= pema_pkg::ST_READ;
            save_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == pema_pkg::S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                pema_pkg::S_READ: begin
                    in_range_reg <= in_rng;
                    gap_reg      <= gap_c;
                    den_reg      <= 48'(bpk_eff) * 48'(gap_c);
                    est_reg      <= '0;
                    save_reg     <= 1'b0;
                    do_mem_reg   <= 1'b0;
                    if (is_pulse) begin
                        last_edge_reg <= time_reg;
                        edge_seen_reg <= 1'b1;
                        if (glitch) begin
                            glitch_reg <= glitch_reg + 32'd1;
                            status_reg <= pema_pkg::ST_LOST;
                        end else begin
                            last_beat_reg   <= time_reg;
                            beat_seen_reg   <= 1'b1;
                            total_beats_reg <= total_beats_reg + 32'd1;
                            if (kwh_done) begin
                                kwh_reg    <= kwh_reg + 32'd1;
                                do_mem_reg <= in_rng;
                                if (balance_reg != 32'd0) begin
                                    balance_reg <= balance_reg - 32'd1;
                                    if ((balance_reg - 32'd1) < minb_cfg_reg)
                                        relay_reg <= 1'b0;
                                end
                                save_reg   <= 1'b1;
                                status_reg <= pema_pkg::ST_KWH;
                            end else begin
                                beat_in_kwh_reg <= beat_next;
                                status_reg <= pema_pkg::ST_BEAT;
                            end
                        end
                    end else if (cmd_reg == pema_pkg::CMD_LOAD) begin
                        balance_reg <= bval_reg;
                        relay_reg   <= 1'b1;
                        status_reg  <= pema_pkg::ST_LOADED;
                    end else begin
                        status_reg <= pema_pkg::ST_READ;
                    end
                end
                pema_pkg::S_DIV: begin
                    if (!div_ctl.busy && gap_reg != 32'd0 &&
                        (status_reg == pema_pkg::ST_BEAT || status_reg == pema_pkg::ST_KWH)) begin
                        est_reg <= quot;
                        if (quot > peak_reg) peak_reg <= quot;
                        if (quot < floor_reg && quot != 16'd0) floor_reg <= quot;
                    end
                    // remainder done: wrap the beat count or test the checkpoint
                    if (!mod_busy_reg) begin
                        if (status_reg == pema_pkg::ST_KWH) beat_in_kwh_reg <= mod_rem_reg;
                        if (status_reg == pema_pkg::ST_BEAT) save_reg <= (mod_rem_reg == 16'd0);
                    end
                end
                pema_pkg::S_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
        if (s_acc) begin
            cmd_reg  <= in_cmd;
            time_reg <= in_time;
            mon_reg  <= in_mon;
            hr_reg   <= in_hr;
            bval_reg <= in_bval;
        end
        // result register; memory data still holds the pre-write count here
        if (state_reg == pema_pkg::S_OUT) begin
            out_data_reg <= {3'd0, total_beats_reg, glitch_reg,
                             in_range_reg ? (do_mem_reg ? hour_rdata + 8'd1 : hour_rdata)
                                          : 8'd0,
                             in_range_reg ? (do_mem_reg ? mon_rdata + 16'd1 : mon_rdata)
                                          : 16'd0,
                             balance_reg, kwh_reg, floor_reg, peak_reg, est_reg,
                             relay_reg, save_reg, status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // divider never runs outside the divide state
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.busy |-> state_reg == pema_pkg::S_DIV)
        else $error("divider busy outside divide state");
    // no item taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_tready)
        else $error("input ready while result pending");
    // counter memory only written while clearing or on a kwh completion
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == pema_pkg::S_WRITE) |-> status_reg == pema_pkg::ST_KWH)
        else $error("counter write without kwh");
endmodule

FILE: tb/pulse_energy_meter_accumulator_tb.sv
`timescale 1ns / 1ps
module pulse_energy_meter_accumulator_tb;
    import pema_pkg::*;

    // one result item, unpacked
    typedef struct {
        logic [2:0]  status;
        logic        save;
        logic        relay;
        logic [15:0] est;
        logic [15:0] peak;
        logic [15:0] floor_cur;
        logic [31:0] kwh;
        logic [31:0] bal;
        logic [15:0] mon_kwh;
        logic [7:0]  hr_kwh;
        logic [31:0] lost;
        logic [31:0] beats;
    } meter_out_t;

    // shadow of the meter state and its expected results
    class meter_scoreboard;
        logic [15:0] bpk_reg, gap_reg;
        logic [31:0] minb_reg;
        logic [39:0] num_reg;
        logic [15:0] beat_in_kwh, peak, floor_cur;
        logic [31:0] total_beats, last_edge, last_beat, kwh, bal, glitches;
        logic        edge_seen, beat_seen, relay;
        logic [15:0] month_cnt[MONTHS];
        logic [7:0]  hour_cnt[HOUR_ENTRIES];
        meter_out_t  pending[$];
        int          errors;
        int          n_kwh, n_lost, n_est, n_save;

        function new();
            bpk_reg = 16'd1000; gap_reg = 16'd10; minb_reg = 32'd1;
            num_reg = 40'd30000000000;
            beat_in_kwh = 0; peak = 0; floor_cur = FLOOR_RESET;
            total_beats = 0; last_edge = 0; last_beat = 0; kwh = 0; bal = 0;
            glitches = 0; edge_seen = 0; beat_seen = 0; relay = 1;
            foreach (month_cnt[i]) month_cnt[i] = 0;
            foreach (hour_cnt[i]) hour_cnt[i] = 0;
            errors = 0; n_kwh = 0; n_lost = 0; n_est = 0; n_save = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [63:0] v);
            case (idx)
                REG_BPK:  bpk_reg = v[15:0];
                REG_GAP:  gap_reg = v[15:0];
                REG_MINB: minb_reg = v[31:0];
                default:  num_reg = v[39:0];
            endcase
        endfunction

        // apply one accepted input item
        function void note_input(logic [79:0] d);
            cmd_t        cmd;
            logic [31:0] t, bval, gap, bpk, dv;
            logic [3:0]  mon;
            logic [4:0]  hr;
            logic        in_rng;
            logic [63:0] den, q;
            meter_out_t  r;
            cmd = cmd_t'(d[1:0]); t = d[33:2]; mon = d[37:34]; hr = d[42:38];
            bval = d[74:43];
            in_rng = (mon < MONTHS) && (hr < HOURS);
            r.status = ST_READ; r.save = 0; r.est = 0;
            if (cmd == CMD_PULSE) begin
                if (edge_seen && (t - last_edge) <= {16'd0, gap_reg}) begin
                    glitches++;
                    r.status = ST_LOST;
                    n_lost++;
                end else begin
                    bpk = (bpk_reg == 0) ? 32'd1000 : {16'd0, bpk_reg};
                    dv = bpk / 100;
                    if (dv == 0) dv = 1;
                    gap = beat_seen ? t - last_beat : 32'd0;
                    last_beat = t; beat_seen = 1;
                    beat_in_kwh = beat_in_kwh + 16'd1;
                    total_beats++;
                    if (gap != 0) begin
                        den = {32'd0, bpk} * {32'd0, gap};
                        q = {24'd0, num_reg} / den;
                        r.est = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
                        if (r.est > peak) peak = r.est;
                        if (r.est < floor_cur && r.est != 0) floor_cur = r.est;
                        n_est++;
                    end
                    if ({16'd0, beat_in_kwh} >= bpk) begin
                        kwh++;
                        if (in_rng) begin
                            month_cnt[mon]++;
                            hour_cnt[mon * HOURS + hr]++;
                        end
                        beat_in_kwh = 16'({16'd0, beat_in_kwh} % bpk);
                        if (bal != 0) begin
                            bal--;
                            if (bal < minb_reg) relay = 0;
                        end
                        r.save = 1; r.status = ST_KWH;
                        n_kwh++;
                    end else begin
                        if ({16'd0, beat_in_kwh} % dv == 0) r.save = 1;
                        r.status = ST_BEAT;
                    end
                end
                last_edge = t; edge_seen = 1;
            end else if (cmd == CMD_LOAD) begin
                bal = bval; relay = 1; r.status = ST_LOADED;
            end
            if (r.save) n_save++;
            r.relay = relay; r.peak = peak; r.floor_cur = floor_cur; r.kwh = kwh;
            r.bal = bal; r.lost = glitches; r.beats = total_beats;
            r.mon_kwh = in_rng ? month_cnt[mon] : 16'd0;
            r.hr_kwh = in_rng ? hour_cnt[mon * HOURS + hr] : 8'd0;
            pending.push_back(r);
        endfunction

        function void mismatch(string what, logic [31:0] e, logic [31:0] a);
            if (errors < 10) $display("mismatch %s: expected %0h got %0h", what, e, a);
            errors++;
        endfunction

        // compare one accepted result item
        function void check_result(logic [207:0] d);
            meter_out_t e;
            if (pending.size() == 0) begin
                if (errors < 10) $display("result item with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] !== e.status) mismatch("status", e.status, d[2:0]);
            if (d[3] !== e.save) mismatch("save_request", e.save, d[3]);
            if (d[4] !== e.relay) mismatch("relay_closed", e.relay, d[4]);
            if (d[20:5] !== e.est) mismatch("current_estimate", e.est, d[20:5]);
            if (d[36:21] !== e.peak) mismatch("max_current", e.peak, d[36:21]);
            if (d[52:37] !== e.floor_cur) mismatch("min_current", e.floor_cur, d[52:37]);
            if (d[84:53] !== e.kwh) mismatch("lifetime_kwh", e.kwh, d[84:53]);
            if (d[116:85] !== e.bal) mismatch("prepaid_balance", e.bal, d[116:85]);
            if (d[132:117] !== e.mon_kwh) mismatch("month_kwh", e.mon_kwh, d[132:117]);
            if (d[140:133] !== e.hr_kwh) mismatch("hour_kwh", e.hr_kwh, d[140:133]);
            if (d[172:141] !== e.lost) mismatch("lost_pulses", e.lost, d[172:141]);
            if (d[204:173] !== e.beats) mismatch("lifetime_beats", e.beats, d[204:173]);
        endfunction
    endclass

    logic         aclk, aresetn;
    logic         s_tvalid, s_tready;
    logic [79:0]  s_tdata;
    logic         m_tvalid, m_tready;
    logic [207:0] m_tdata;
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [63:0]  pwdata, prdata;

    pulse_energy_meter_accumulator dut (.*);

    meter_scoreboard meter;
    logic [31:0] clock_ms;
    int  idle_cycles;
    bit  no_stall;

    // clock
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // accepted items on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) meter.note_input(s_tdata);
            if (m_tvalid && m_tready) meter.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no accepted item or register access (covers clearing after reset)
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("watchdog: no progress");
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial begin
        int n;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (!no_stall && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                m_tready = 0;
                repeat (n) @(negedge aclk);
            end
            m_tready = 1;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [63:0] v);
        @(negedge aclk);
        psel = 1; penable = 0; pwrite = 1; paddr = 5'(idx) << 3; pwdata = v;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        meter.set_reg(idx, v);
    endtask

    task automatic wait_drained();
        while (meter.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    // send one item, with an optional random gap ahead of it
    task automatic send_item(cmd_t cmd, logic [31:0] t, logic [3:0] mon,
                             logic [4:0] hr, logic [31:0] bval, bit may_gap);
        if (may_gap && !no_stall && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        s_tdata = {5'd0, bval, hr, mon, t, cmd};
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic pulse(logic [31:0] dt, bit may_gap);
        clock_ms = clock_ms + dt;
        send_item(CMD_PULSE, clock_ms, 4'($urandom_range(0, 11)),
                  5'($urandom_range(0, 23)), $urandom, may_gap);
    endtask

    // random item mix, mostly well-formed pulse trains
    task automatic random_items(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 70) pulse($urandom_range(5, 3000), 1);
            else if (k < 78) pulse($urandom_range(0, 12), 1);
            else if (k < 82) pulse($urandom, 1);
            else if (k < 88) send_item(CMD_LOAD, $urandom, 4'($urandom), 5'($urandom),
                                       ($urandom_range(0, 1) ? $urandom_range(0, 4)
                                                              : $urandom), 1);
            else if (k < 96) send_item(CMD_READ, $urandom, 4'($urandom_range(0, 11)),
                                       5'($urandom_range(0, 23)), $urandom, 1);
            else send_item(cmd_t'($urandom_range(2, 3)), $urandom, 4'($urandom),
                           5'($urandom), $urandom, 1);
        end
    endtask

    initial begin
        meter = new();
        clock_ms = 0; idle_cycles = 0; no_stall = 0;
        s_tvalid = 0; s_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        aresetn = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1;

        // directed: first edge, glitch, read/load extremes, command 3
        send_item(CMD_PULSE, 32'hFFFF_FFF0, 4'd11, 5'd23, 32'hFFFF_FFFF, 0);
        send_item(CMD_PULSE, 32'hFFFF_FFF5, 4'd0, 5'd0, 32'd0, 0);
        send_item(CMD_PULSE, 32'd20, 4'd0, 5'd0, 32'd0, 0);
        send_item(CMD_PULSE, 32'd20, 4'd0, 5'd0, 32'd0, 0);
        send_item(CMD_LOAD, 32'd0, 4'd15, 5'd31, 32'hFFFF_FFFF, 0);
        send_item(CMD_LOAD, 32'd0, 4'd0, 5'd0, 32'd2, 0);
        send_item(CMD_READ, 32'hFFFF_FFFF, 4'd15, 5'd31, 32'd0, 0);
        send_item(CMD_READ3, 32'd0, 4'd11, 5'd23, 32'hFFFF_FFFF, 0);
        wait_drained();

        // small bpk: kWh often, balance runs out, relay opens; gap 0, bpk 1
        reg_write(REG_BPK, 64'd1);
        reg_write(REG_GAP, 64'd0);
        reg_write(REG_MINB, 64'd2);
        reg_write(REG_NUM, 64'd1);
        clock_ms = 100;
        for (int i = 0; i < 4; i++) pulse(i == 0 ? 0 : 1, 0);
        send_item(CMD_PULSE, 32'd300, 4'd12, 5'd24, 32'd0, 0);
        wait_drained();
        reg_write(REG_NUM, 64'hFF_FFFF_FFFF);
        reg_write(REG_MINB, 64'hFFFF_FFFF);
        pulse(1, 0);
        pulse(32'hFFFF_FFFF, 0);
        wait_drained();

        // random phases over several settings
        reg_write(REG_BPK, 64'd3);  reg_write(REG_GAP, 64'd10);
        reg_write(REG_MINB, 64'd0); reg_write(REG_NUM, 64'd30000000000);
        random_items(150);
        // sender holds off until all results are back
        wait_drained();
        reg_write(REG_BPK, 64'd0);  reg_write(REG_GAP, 64'hFFFF);
        reg_write(REG_MINB, 64'd1);
        random_items(40);
        wait_drained();
        reg_write(REG_BPK, 64'd250); reg_write(REG_GAP, 64'd2);
        reg_write(REG_NUM, 64'd1000000);
        random_items(100);
        wait_drained();
        reg_write(REG_BPK, 64'hFFFF); reg_write(REG_GAP, 64'd5);
        random_items(50);
        wait_drained();
        reg_write(REG_BPK, 64'd2); reg_write(REG_MINB, 64'd3);
        reg_write(REG_NUM, 64'd1);
        random_items(80);
        no_stall = 1;
        random_items(80);
        wait_drained();

        $display("covered %0d kWh completions, %0d lost pulses, %0d estimates, %0d saves",
                 meter.n_kwh, meter.n_lost, meter.n_est, meter.n_save);
        if (meter.errors == 0 && meter.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", meter.errors,
                     meter.pending.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
